@@ hw/rtl/dur_pkg.sv @@
// dur_pkg: shared types and constants for the dual ultrasonic ranger
// no dependencies; imported by the interfaces, the channel and the top level
package dur_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned RANGE_W = 12;
    localparam int unsigned THR_W   = 12;
    localparam int unsigned HYST_W  = 10;
    localparam int unsigned PAUSE_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // echo width to millimeters: (ticks * 1115) >> 15
    localparam int unsigned SCALE_MUL_W = 11;
    localparam int unsigned PROD_W      = TICK_W + SCALE_MUL_W;
    localparam int unsigned SCALE_SHIFT = 15;
    localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 11'd1115;

    localparam logic [RANGE_W-1:0] NO_ECHO_MM     = 12'd2000;
    localparam logic [RANGE_W-1:0] RANGE_RESET_MM = 12'd3000;
    localparam logic [TICK_W-1:0]  TICK_SAT       = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 3'd4;

    // per-tick control from the sequencer to each channel
    typedef struct packed {
        logic              capture;   // accepted tick, listening, a pin changed
        logic              finish;    // accepted tick that ends the listen period
        logic [TICK_W-1:0] tick;      // tick count before this tick's update
    } chan_ctl_t;

endpackage

@@ hw/rtl/dur_if.sv @@
// dur_if: valid/ready channels of the dual ultrasonic ranger
// depends on dur_pkg for field widths
interface dur_tick_if;
    import dur_pkg::*;

    logic valid;
    logic ready;
    logic front_echo;
    logic rear_echo;

    modport source (output valid, output front_echo, output rear_echo, input ready);
    modport sink   (input valid, input front_echo, input rear_echo, output ready);
endinterface

interface dur_result_if;
    import dur_pkg::*;

    logic               valid;
    logic               ready;
    logic               trigger_drive;
    logic [RANGE_W-1:0] front_distance_mm;
    logic [RANGE_W-1:0] rear_distance_mm;
    logic               front_clear;
    logic               rear_clear;
    logic               measure_done;

    modport source (
        output valid, output trigger_drive, output front_distance_mm,
        output rear_distance_mm, output front_clear, output rear_clear,
        output measure_done, input ready
    );
    modport sink (
        input valid, input trigger_drive, input front_distance_mm,
        input rear_distance_mm, input front_clear, input rear_clear,
        input measure_done, output ready
    );
endinterface

@@ hw/rtl/dual_ultrasonic_ranger_top.sv @@
// dual_ultrasonic_ranger_top: ping sequencer and two echo channels
// the result word of a tick is registered and valid in the cycle after the tick is taken
// one tick word per cycle while the result is drained; the state registers double as the result register
// reset: waiting to send, counters and captures cleared, ranges 3000 mm, flags clear
// depends on dur_pkg, dur_if.sv and dur_channel
module dual_ultrasonic_ranger_top (
    input  logic                           clk,
    input  logic                           rst_n,
    dur_tick_if.sink                       tick,
    dur_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [dur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dur_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dur_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT_SEND,
        PH_SEND,
        PH_LISTEN,
        PH_PAUSE
    } phase_t;

    // configuration registers
    logic [THR_W-1:0]   threshold_reg;
    logic [HYST_W-1:0]  hysteresis_reg;
    logic [TICK_W-1:0]  trigger_reg;
    logic [TICK_W-1:0]  listen_reg;
    logic [PAUSE_W-1:0] pause_periods_reg;

    // sequencer state
    phase_t             phase_reg;
    logic [TICK_W-1:0]  tick_count_reg;
    logic [PAUSE_W-1:0] pause_count_reg;
    logic               front_prev_reg;
    logic               rear_prev_reg;

    // result handshake; distances, flags and trigger come straight from state,
    // which only moves on an accepted tick and so holds while the word stalls
    logic out_valid_reg;
    logic done_reg;

    logic              accept;
    logic              pin_change;
    logic              wrap;
    logic [TICK_W-1:0] period;
    chan_ctl_t         ctl;

    logic [RANGE_W-1:0] front_range, rear_range;
    logic               front_det, rear_det;

    // a new tick goes in whenever the result slot is empty or being drained
    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    assign pin_change = (tick.front_echo != front_prev_reg) || (tick.rear_echo != rear_prev_reg);
    assign period     = (phase_reg == PH_SEND) ? trigger_reg : listen_reg;
    assign wrap       = (tick_count_reg == period);

    // both channels see the same capture and end-of-listen strobes
    assign ctl.capture = accept && (phase_reg == PH_LISTEN) && pin_change;
    assign ctl.finish  = accept && (phase_reg == PH_LISTEN) && wrap;
    assign ctl.tick    = tick_count_reg;

    dur_channel u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .level         (tick.front_echo),
        .threshold_mm  (threshold_reg),
        .hysteresis_mm (hysteresis_reg),
        .range_mm      (front_range),
        .detected      (front_det)
    );

    dur_channel u_rear (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .level         (tick.rear_echo),
        .threshold_mm  (threshold_reg),
        .hysteresis_mm (hysteresis_reg),
        .range_mm      (rear_range),
        .detected      (rear_det)
    );

    // configuration writes, to be issued only while the block is idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= 12'd400;
            hysteresis_reg    <= 10'd50;
            trigger_reg       <= 16'd200;
            listen_reg        <= 16'd65535;
            pause_periods_reg <= 4'd6;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  threshold_reg     <= cfg_data[THR_W-1:0];
                CFG_HYSTERESIS: hysteresis_reg    <= cfg_data[HYST_W-1:0];
                CFG_TRIGGER:    trigger_reg       <= cfg_data[TICK_W-1:0];
                CFG_LISTEN:     listen_reg        <= cfg_data[TICK_W-1:0];
                CFG_PAUSE:      pause_periods_reg <= cfg_data[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // phase sequencer and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT_SEND;
            tick_count_reg  <= '0;
            pause_count_reg <= '0;
            front_prev_reg  <= 1'b0;
            rear_prev_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg  <= 1'b1;
                front_prev_reg <= tick.front_echo;
                rear_prev_reg  <= tick.rear_echo;
                done_reg       <= ctl.finish;
                if (wrap)
                begin
                    tick_count_reg <= '0;
                    unique case (phase_reg)
                        PH_WAIT_SEND: phase_reg <= PH_SEND;
                        PH_SEND:      phase_reg <= PH_LISTEN;
                        PH_LISTEN:
                        begin
                            phase_reg       <= PH_PAUSE;
                            pause_count_reg <= PAUSE_W'(1);
                        end
                        PH_PAUSE:
                        begin
                            if (pause_count_reg >= pause_periods_reg)
                                phase_reg <= PH_WAIT_SEND;
                            else
                                pause_count_reg <= pause_count_reg + PAUSE_W'(1);
                        end
                        default: phase_reg <= PH_WAIT_SEND;
                    endcase
                end
                else
                begin
                    // wraps modulo 2^16 if the period was set below the count
                    tick_count_reg <= tick_count_reg + TICK_W'(1);
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.trigger_drive     = (phase_reg == PH_SEND);
    assign result.front_distance_mm = front_range;
    assign result.rear_distance_mm  = rear_range;
    assign result.front_clear       = !front_det;
    assign result.rear_clear        = !rear_det;
    assign result.measure_done      = done_reg;

endmodule

@@ hw/rtl/dur_channel.sv @@
// dur_channel: echo capture, range scaling and hysteresis flag of one sensor
// depends on dur_pkg
module dur_channel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dur_pkg::chan_ctl_t          ctl,
    input  logic                        level,
    input  logic [dur_pkg::THR_W-1:0]   threshold_mm,
    input  logic [dur_pkg::HYST_W-1:0]  hysteresis_mm,
    output logic [dur_pkg::RANGE_W-1:0] range_mm,
    output logic                        detected
);
    import dur_pkg::*;

    localparam int unsigned CMP_W = THR_W + 2;

    logic [TICK_W-1:0]  rise_reg, rise_next;
    logic [TICK_W-1:0]  fall_reg, fall_next;
    logic [RANGE_W-1:0] range_reg;
    logic               det_reg;

    logic [TICK_W-1:0]        width_ticks;
    logic [PROD_W-1:0]        prod;
    logic [RANGE_W-1:0]       range_calc;
    logic signed [CMP_W-1:0]  r_s, upper_s, lower_s;
    logic                     det_calc;

    // edge capture, a rise stored at count zero reads as unset
    always_comb
    begin
        rise_next = rise_reg;
        fall_next = fall_reg;
        if (ctl.capture)
        begin
            if (level)
            begin
                if (rise_reg == '0)
                    rise_next = ctl.tick;
            end
            else if (fall_reg == '0 && rise_reg != '0)
            begin
                fall_next = (ctl.tick < rise_reg) ? TICK_SAT : ctl.tick;
            end
        end
    end

    assign width_ticks = fall_next - rise_next;
    assign prod        = PROD_W'(width_ticks) * PROD_W'(SCALE_MUL);
    assign range_calc  = (fall_next == '0) ? NO_ECHO_MM : prod[PROD_W-1:SCALE_SHIFT];

    // signed band, a negative lower bound never sets the flag
    assign r_s     = signed'(CMP_W'(range_calc));
    assign upper_s = signed'(CMP_W'(threshold_mm)) + signed'(CMP_W'(hysteresis_mm));
    assign lower_s = signed'(CMP_W'(threshold_mm)) - signed'(CMP_W'(hysteresis_mm));
    assign det_calc = det_reg ? !(r_s > upper_s) : (r_s < lower_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg  <= '0;
            fall_reg  <= '0;
            range_reg <= RANGE_RESET_MM;
            det_reg   <= 1'b0;
        end
        else if (ctl.finish)
        begin
            rise_reg  <= '0;
            fall_reg  <= '0;
            range_reg <= range_calc;
            det_reg   <= det_calc;
        end
        else
        begin
            rise_reg <= rise_next;
            fall_reg <= fall_next;
        end
    end

    assign range_mm = range_reg;
    assign detected = det_reg;

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for dual_ultrasonic_ranger_top, tick words in, result words out
// depends on dur_pkg, the channel interfaces in dur_if.sv and the ranger RTL
`timescale 1ns / 100ps

module testbench;
    import dur_pkg::*;

    // sequencer phases, in the encoding the block steps through
    typedef enum logic [1:0] {PH_WAIT, PH_SEND, PH_LISTEN, PH_PAUSE} ping_phase_t;

    // one result word, fields in port order
    typedef struct packed {
        logic               trigger_drive;
        logic [RANGE_W-1:0] front_distance_mm;
        logic [RANGE_W-1:0] rear_distance_mm;
        logic               front_clear;
        logic               rear_clear;
        logic               measure_done;
    } ranger_word_t;

    // cycles with no word moving on either side before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    // mirror of the ping sequencer and both echo channels, plus the words still owed
    class ranger_scoreboard;
        logic [THR_W-1:0]   threshold;
        logic [HYST_W-1:0]  hysteresis;
        logic [TICK_W-1:0]  trigger_len;
        logic [TICK_W-1:0]  listen_len;
        logic [PAUSE_W-1:0] pause_len;
        ping_phase_t        phase;
        logic [TICK_W-1:0]  tick_count;
        logic [PAUSE_W-1:0] pause_count;
        logic [TICK_W-1:0]  front_rise, front_fall, rear_rise, rear_fall;
        logic [RANGE_W-1:0] front_mm, rear_mm;
        logic               front_hit, rear_hit;
        logic               front_last, rear_last;
        ranger_word_t       pending_words[$];
        int                 errors;
        int                 measurements;

        function new();
            threshold    = 12'd400;
            hysteresis   = 10'd50;
            trigger_len  = 16'd200;
            listen_len   = 16'hFFFF;
            pause_len    = 4'd6;
            phase        = PH_WAIT;
            tick_count   = '0;
            pause_count  = '0;
            front_rise   = '0;
            front_fall   = '0;
            rear_rise    = '0;
            rear_fall    = '0;
            front_mm     = RANGE_RESET_MM;
            rear_mm      = RANGE_RESET_MM;
            front_hit    = 1'b0;
            rear_hit     = 1'b0;
            front_last   = 1'b0;
            rear_last    = 1'b0;
            errors       = 0;
            measurements = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_THRESHOLD:  threshold   = value[THR_W-1:0];
                CFG_HYSTERESIS: hysteresis  = value[HYST_W-1:0];
                CFG_TRIGGER:    trigger_len = value[TICK_W-1:0];
                CFG_LISTEN:     listen_len  = value[TICK_W-1:0];
                CFG_PAUSE:      pause_len   = value[PAUSE_W-1:0];
                default: ;
            endcase
        endfunction

        // a zero capture means unset, a fall before the rise saturates
        function void latch_echo(input logic level, inout logic [TICK_W-1:0] rise,
                                 inout logic [TICK_W-1:0] fall);
            if (level) begin
                if (rise == 0)
                    rise = tick_count;
            end
            else if (fall == 0 && rise != 0) begin
                fall = (tick_count < rise) ? TICK_SAT : tick_count;
            end
        endfunction

        function logic [RANGE_W-1:0] echo_mm(logic [TICK_W-1:0] rise, logic [TICK_W-1:0] fall);
            logic [TICK_W-1:0] width;
            logic [PROD_W-1:0] prod;
            if (fall == 0)
                return NO_ECHO_MM;
            width = fall - rise;
            prod  = width * SCALE_MUL;
            return RANGE_W'(prod >> SCALE_SHIFT);
        endfunction

        // signed band: a negative lower bound never sets the flag
        function logic next_hit(logic hit, logic [RANGE_W-1:0] mm);
            int thr;
            int hy;
            int r;
            thr = int'(threshold);
            hy  = int'(hysteresis);
            r   = int'(mm);
            if (hit)
                return !(r > thr + hy);
            return r < thr - hy;
        endfunction

        function void take_tick(logic fe, logic re);
            logic [TICK_W-1:0] period;
            ranger_word_t      word;
            logic              done;
            done = 1'b0;
            if (phase == PH_LISTEN && (fe != front_last || re != rear_last)) begin
                latch_echo(fe, front_rise, front_fall);
                latch_echo(re, rear_rise, rear_fall);
            end
            front_last = fe;
            rear_last  = re;

            period = (phase == PH_SEND) ? trigger_len : listen_len;
            if (tick_count == period) begin
                tick_count = '0;
                case (phase)
                    PH_WAIT:   phase = PH_SEND;
                    PH_SEND:   phase = PH_LISTEN;
                    PH_LISTEN: begin
                        front_mm    = echo_mm(front_rise, front_fall);
                        rear_mm     = echo_mm(rear_rise, rear_fall);
                        front_hit   = next_hit(front_hit, front_mm);
                        rear_hit    = next_hit(rear_hit, rear_mm);
                        front_rise  = '0;
                        front_fall  = '0;
                        rear_rise   = '0;
                        rear_fall   = '0;
                        pause_count = 4'd1;
                        phase       = PH_PAUSE;
                        done        = 1'b1;
                        measurements++;
                    end
                    default: begin
                        if (pause_count >= pause_len)
                            phase = PH_WAIT;
                        else
                            pause_count = pause_count + 1'b1;
                    end
                endcase
            end
            else begin
                tick_count = tick_count + 1'b1;
            end

            word.trigger_drive     = (phase == PH_SEND);
            word.front_distance_mm = front_mm;
            word.rear_distance_mm  = rear_mm;
            word.front_clear       = ~front_hit;
            word.rear_clear        = ~rear_hit;
            word.measure_done      = done;
            pending_words.push_back(word);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(ranger_word_t got);
            ranger_word_t want;
            if (pending_words.size() == 0) begin
                $error("result word with no tick word pending");
                errors++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("trigger_drive", want.trigger_drive, got.trigger_drive);
            compare_field("front_distance_mm", want.front_distance_mm, got.front_distance_mm);
            compare_field("rear_distance_mm", want.rear_distance_mm, got.rear_distance_mm);
            compare_field("front_clear", want.front_clear, got.front_clear);
            compare_field("rear_clear", want.rear_clear, got.rear_clear);
            compare_field("measure_done", want.measure_done, got.measure_done);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dur_tick_if   tick_bus ();
    dur_result_if result_bus ();

    dual_ultrasonic_ranger_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ranger_scoreboard ranger_sb;

    // idling knobs, percent of cycles; hold_request asks the receiver for a long hold-off
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_request;

    // echo pattern generator state, one run length per pin
    logic front_lvl;
    logic rear_lvl;
    int   front_run;
    int   rear_run;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: checks every result word taken, then picks next cycle's ready
    initial
    begin : receiver
        int           hold_left;
        ranger_word_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready) begin
                got = {result_bus.trigger_drive, result_bus.front_distance_mm,
                       result_bus.rear_distance_mm, result_bus.front_clear,
                       result_bus.rear_clear, result_bus.measure_done};
                ranger_sb.check_word(got);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else begin
                result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: too long with no word moving on either channel means a hang
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((tick_bus.valid && tick_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // offer one tick word, with a random idle gap in front, and wait until taken
    task automatic send_tick(input logic fe, input logic re);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_bus.valid      <= 1'b1;
        tick_bus.front_echo <= fe;
        tick_bus.rear_echo  <= re;
        do
            @(posedge clk);
        while (tick_bus.ready !== 1'b1);
        ranger_sb.take_tick(fe, re);
    endtask

    // hold the pins until the sequencer sits at the given phase and count
    task automatic drive_until(input ping_phase_t ph, input int count,
                               input logic fe, input logic re);
        while (!(ranger_sb.phase == ph && ranger_sb.tick_count == count))
            send_tick(fe, re);
    endtask

    // let the counter come back to zero so a smaller period cannot make it wrap
    task automatic rewind_counter();
        while (ranger_sb.tick_count != 0)
            send_tick(1'b0, 1'b0);
    endtask

    // stop offering and wait for every owed word
    task automatic settle();
        tick_bus.valid <= 1'b0;
        while (ranger_sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        ranger_sb.write_reg(index, value[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int unsigned thr, input int unsigned hyst,
                             input int unsigned trig, input int unsigned listen,
                             input int unsigned pauses);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_HYSTERESIS, hyst);
        write_reg(CFG_TRIGGER, trig);
        write_reg(CFG_LISTEN, listen);
        write_reg(CFG_PAUSE, pauses);
        cfg_wr_en <= 1'b0;
    endtask

    // pin levels hold for random runs, so pulses straddle every phase; some ticks are noise
    task automatic step_echo(inout logic level, inout int run,
                             input int max_run, input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            level = 1'($urandom_range(0, 1));
        else if (run == 0) begin
            level = ~level;
            run   = $urandom_range(1, max_run);
        end
        else
            run--;
    endtask

    task automatic run_random(input int items, input int max_run, input int noise_pct);
        repeat (items)
        begin
            step_echo(front_lvl, front_run, max_run, noise_pct);
            step_echo(rear_lvl, rear_run, max_run, noise_pct);
            send_tick(front_lvl, rear_lvl);
        end
    endtask

    initial
    begin : stimulus
        int unsigned thr;
        int unsigned hyst;
        int unsigned trig;
        int unsigned listen;
        int unsigned pauses;
        int          done_goal;

        ranger_sb = new();
        rst_n               <= 1'b0;
        tick_bus.valid      <= 1'b0;
        tick_bus.front_echo <= 1'b0;
        tick_bus.rear_echo  <= 1'b0;
        result_bus.ready    <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= CFG_THRESHOLD;
        cfg_data            <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        front_lvl      = 1'b0;
        rear_lvl       = 1'b0;
        front_run      = 0;
        rear_run       = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short ping cycle: detect below 1 mm, clear above 3 mm
        configure(2, 1, 1, 6, 1);
        drive_until(PH_LISTEN, 0, 1'b0, 1'b0);
        // front rises on the first listen tick: captured at count zero, so it reads unset
        send_tick(1'b1, 1'b0);
        drive_until(PH_LISTEN, 2, 1'b1, 1'b0);
        // rear change makes both channels capture, front takes its rise again here
        send_tick(1'b1, 1'b1);
        drive_until(PH_LISTEN, 5, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        drive_until(PH_PAUSE, 1, 1'b0, 1'b0);
        // pin edges outside the listen window only move the previous levels
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        settle();

        // longer listen window, ranges of a few mm around the band
        configure(3, 1, 10, 120, 1);
        done_goal = ranger_sb.measurements + 2;
        while (ranger_sb.measurements < done_goal)
            run_random(1, 90, 1);
        rewind_counter();
        settle();

        // random settings with short periods, rotating through the idling modes
        for (int k = 0; k < 8; k++)
        begin
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            trig   = $urandom_range(1, 4);
            listen = $urandom_range(4, 40);
            pauses = $urandom_range(1, 3);
            case (k)
                0: begin
                    // shortest periods, longest pause, lower bound of the band negative
                    thr = 0; hyst = 1000; trig = 1; listen = 1; pauses = 15;
                end
                1: begin thr = 3000; hyst = 0; pauses = 15; end
                2: begin thr = 3000; hyst = 1000; end
                default: begin
                    // either around the sub-mm ranges or around the no-echo value
                    thr  = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(1990, 2010);
                    hyst = $urandom_range(0, 12);
                end
            endcase
            configure(thr, hyst, trig, listen, pauses);
            // receiver holds off long enough for the block to back up its input
            if (k == 4)
                hold_request = 300;
            run_random(110, listen, 5);
            rewind_counter();
            settle();
        end

        // largest periods: the sequencer stays in whichever phase it is in
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(1500, 500, 65535, 65535, 15);
        run_random(40, 8, 20);
        settle();

        if (ranger_sb.errors == 0 && ranger_sb.pending_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dur_pkg.sv
hw/rtl/dur_if.sv
hw/rtl/dur_channel.sv
hw/rtl/dual_ultrasonic_ranger_top.sv
dv/testbench.sv
